>>> design/vae_pkg.sv
// Shared constants, register and status codes, and saturation helper for the estimator.
`default_nettype none

package vae_pkg;

  localparam int unsigned TICKS_DEFAULT = 1000000;

  localparam int unsigned GAIN_W = 17;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 17'd19661;
  localparam logic [31:0] MIN_INTERVAL_RESET = 32'd1000;
  localparam logic [31:0] MAX_INTERVAL_RESET = 32'd100000;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FILTER_GAIN  = 2'd0,
    REG_MIN_INTERVAL = 2'd1,
    REG_MAX_INTERVAL = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STATUS_FIRST   = 2'd0,
    STATUS_SKIPPED = 2'd1,
    STATUS_UPDATED = 2'd2
  } status_t;

  // Applies a sign to an unsigned magnitude and clamps it to the signed 32-bit range.
  function automatic logic signed [31:0] saturate_s32(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (|mag[63:31]) begin
      r = neg ? 32'sh80000000 : 32'sh7fffffff;
    end else if (neg) begin
      r = -$signed(mag[31:0]);
    end else begin
      r = $signed(mag[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/vae_mul_ser.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module vae_mul_ser #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [AW-1:0] a,
  input  wire logic [BW-1:0] b,
  output logic               busy,
  output logic [AW+BW-1:0]   product
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW-1:0] a_r;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [CW-1:0] cnt;
  logic [AW:0]   sum;

  // The low half doubles as the multiplier shift register.
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : '0);
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(BW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      {hi, lo} <= {sum, lo[BW-1:1]};
    end
  end

endmodule

`default_nettype wire

>>> design/vae_div_ser.sv
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module vae_div_ser #(
  parameter int unsigned NW = 54,
  parameter int unsigned DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quotient
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [NW-1:0] quo;
  logic [CW-1:0] cnt;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          fits;

  // Numerator bits leave the top of quo while quotient bits enter at the bottom.
  assign shifted  = {rem, quo[NW-1]};
  assign fits     = shifted >= {1'b0, den_r};
  assign trial    = shifted - {1'b0, den_r};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem   <= '0;
      quo   <= num;
    end else if (busy) begin
      rem <= fits ? trial[DW-1:0] : shifted[DW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

endmodule

`default_nettype wire

>>> design/velocity_to_accel_estimator.sv
// Top level: acceleration estimator from odometry samples with exponential smoothing.
// A request on the input channel (in_valid/in_ready) carries a microsecond timestamp,
// a forward speed and a yaw rate in signed Q16.16. Every request yields exactly one
// result on the output channel (out_valid/out_ready) with the three smoothed
// accelerations, a status code and the running update count.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
// and writes the filter gain, the minimum interval or the maximum interval; an index
// beyond those three is ignored. Write it only while no request is in flight.
// Sequence: a request that is only stored (first sample, or interval outside the window)
// passes the difference, check and output steps; an update also runs the bit-serial
// units: a multiply of speed times yaw rate, in parallel with the two
// difference-times-ticks multiplies, a restoring division of an NW-bit dividend for
// both difference quotients side by side, NW being 33 plus the bit width of
// TICKS_PER_SECOND, and a multiply by the gain in each of the three filter lanes.
// A new request is taken only once the sequencer is back in its idle step, after the
// previous result has been loaded into the output register.
// Reset clears the stored sample, the smoothed values and the counter, and loads the
// default configuration. The result sits in an output register; if the receiver
// stalls, the block still accepts one more request and holds its finished result
// until the output register frees up.
`default_nettype none

module velocity_to_accel_estimator
  import vae_pkg::*;
#(
  parameter int unsigned TICKS_PER_SECOND = TICKS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // input request
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [31:0]            timestamp,
  input  wire logic signed [31:0]     linear_velocity,
  input  wire logic signed [31:0]     yaw_rate,
  // result
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic signed [31:0]          forward_accel,
  output logic signed [31:0]          lateral_accel,
  output logic signed [31:0]          angular_accel,
  output logic [1:0]                  status,
  output logic [31:0]                 updates_done,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  // Width of the tick constant, of the scaled difference, and of the dividend
  // (scaled difference plus half the interval for rounding).
  localparam int unsigned TW = $clog2(TICKS_PER_SECOND + 1);
  localparam logic [TW-1:0] TICKS = TW'(TICKS_PER_SECOND);
  localparam int unsigned PW = 32 + TW;
  localparam int unsigned NW = PW + 1;

  // Filter lanes. The filter numerator prev*65536 + g*(raw - prev) fits in 51 bits.
  localparam int unsigned LANES = 3;
  localparam int unsigned LANE_FWD = 0;
  localparam int unsigned LANE_LAT = 1;
  localparam int unsigned LANE_ANG = 2;
  localparam int unsigned FPW = 32 + GAIN_W;
  localparam int unsigned FNW = 51;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIFF  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_DIV   = 9'b000010000,
    S_RAW   = 9'b000100000,
    S_FMUL  = 9'b001000000,
    S_FNUM  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [GAIN_W-1:0] filter_gain;
  logic [31:0]       min_interval;
  logic [31:0]       max_interval;
  logic [GAIN_W-1:0] gain_eff;

  // Sample being worked on and the stored previous sample.
  logic [31:0]        cur_time;
  logic signed [31:0] cur_speed;
  logic signed [31:0] cur_turn;
  logic               have_previous;
  logic [31:0]        previous_time;
  logic signed [31:0] previous_speed;
  logic signed [31:0] previous_turn_rate;

  // Interval and the two differences as sign, zero flag and magnitude.
  logic [31:0] dt;
  logic        dv_neg, dv_zero, dw_neg, dw_zero;
  logic [31:0] dv_mag, dw_mag;
  logic        in_window;
  logic        lat_neg;
  logic [31:0] speed_mag, turn_mag;

  // Filter state and intermediate values, one entry per lane.
  logic signed [31:0]     smoothed [LANES];
  logic signed [31:0]     raw      [LANES];
  logic                   fneg     [LANES];
  logic [31:0]            fmag     [LANES];
  logic [FPW-1:0]         fprod    [LANES];
  logic signed [FNW-1:0]  fnum     [LANES];
  logic [LANES-1:0]       fbusy;
  logic [31:0]            update_counter;
  status_t                item_status;

  // Serial unit handshakes and results.
  logic              mul_start, div_start, filt_start;
  logic              mul_f_busy, mul_a_busy, mul_l_busy, mul_busy;
  logic              div_f_busy, div_a_busy, div_busy;
  logic [PW-1:0]     prod_f, prod_a;
  logic [63:0]       prod_l;
  logic [NW-1:0]     quo_f, quo_a;
  logic [63:0]       lat_round;
  logic [63:0]       q_f, q_a;

  logic accept, out_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  // Gain codes above one behave as exactly one.
  assign gain_eff = filter_gain[GAIN_W-1] ? GAIN_ONE : filter_gain;

  assign in_window = !(dt < min_interval) && !(dt > max_interval);

  assign speed_mag = cur_speed[31] ? 32'(-cur_speed) : 32'(cur_speed);
  assign turn_mag  = cur_turn[31] ? 32'(-cur_turn) : 32'(cur_turn);
  assign lat_neg   = cur_speed[31] ^ cur_turn[31];

  assign mul_busy   = mul_f_busy || mul_a_busy || mul_l_busy;
  assign div_busy   = div_f_busy || div_a_busy;
  assign mul_start  = (state == S_CHECK) && have_previous && in_window;
  assign div_start  = (state == S_MUL) && !mul_busy;
  assign filt_start = (state == S_RAW);

  // Lateral term: Q32.32 product back to Q16.16, rounding half away from zero.
  assign lat_round = prod_l + 64'd32768;

  // A zero interval can only pass an open window; the quotient then saturates
  // toward the sign of the difference, or is zero when nothing changed.
  assign q_f = (dt == '0) ? (dv_zero ? '0 : '1) : 64'(quo_f);
  assign q_a = (dt == '0) ? (dw_zero ? '0 : '1) : 64'(quo_a);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DIFF;
      end
      S_DIFF: state_next = S_CHECK;
      S_CHECK: begin
        if (have_previous && in_window) state_next = S_MUL;
        else state_next = S_OUT;
      end
      S_MUL: begin
        if (!mul_busy) state_next = S_DIV;
      end
      S_DIV: begin
        if (!div_busy) state_next = S_RAW;
      end
      S_RAW: state_next = S_FMUL;
      S_FMUL: begin
        if (!(|fbusy)) state_next = S_FNUM;
      end
      S_FNUM: state_next = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain  <= GAIN_RESET;
      min_interval <= MIN_INTERVAL_RESET;
      max_interval <= MAX_INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FILTER_GAIN:  filter_gain  <= cfg_data[GAIN_W-1:0];
        REG_MIN_INTERVAL: min_interval <= cfg_data;
        REG_MAX_INTERVAL: max_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: capture the request, form dt, differences, status and raw values.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_time  <= timestamp;
      cur_speed <= linear_velocity;
      cur_turn  <= yaw_rate;
    end
    if (state == S_DIFF) begin
      dt      <= cur_time - previous_time;
      dv_neg  <= cur_speed < previous_speed;
      dv_zero <= cur_speed == previous_speed;
      dv_mag  <= (cur_speed < previous_speed) ? 32'(previous_speed - cur_speed)
                                              : 32'(cur_speed - previous_speed);
      dw_neg  <= cur_turn < previous_turn_rate;
      dw_zero <= cur_turn == previous_turn_rate;
      dw_mag  <= (cur_turn < previous_turn_rate) ? 32'(previous_turn_rate - cur_turn)
                                                 : 32'(cur_turn - previous_turn_rate);
    end
    if (state == S_CHECK) begin
      if (!have_previous) begin
        item_status <= STATUS_FIRST;
      end else if (!in_window) begin
        item_status <= STATUS_SKIPPED;
      end
    end
    if (state == S_FNUM) begin
      item_status <= STATUS_UPDATED;
    end
    if (div_start) begin
      raw[LANE_LAT] <= saturate_s32(lat_neg, {16'd0, lat_round[63:16]});
    end
    if ((state == S_DIV) && !div_busy) begin
      raw[LANE_FWD] <= saturate_s32(dv_neg, q_f);
      raw[LANE_ANG] <= saturate_s32(dw_neg, q_a);
    end
  end

  // Stage one: scale the differences by the tick rate and form speed times yaw rate.
  vae_mul_ser #(.AW(32), .BW(TW)) u_mul_fwd (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (dv_mag),
    .b       (TICKS),
    .busy    (mul_f_busy),
    .product (prod_f)
  );

  vae_mul_ser #(.AW(32), .BW(TW)) u_mul_ang (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (dw_mag),
    .b       (TICKS),
    .busy    (mul_a_busy),
    .product (prod_a)
  );

  vae_mul_ser #(.AW(32), .BW(32)) u_mul_lat (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (speed_mag),
    .b       (turn_mag),
    .busy    (mul_l_busy),
    .product (prod_l)
  );

  // Stage two: divide both scaled differences by the interval. Adding half the
  // interval to the dividend rounds the quotient to nearest, ties away from zero.
  vae_div_ser #(.NW(NW), .DW(32)) u_div_fwd (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (NW'(prod_f) + NW'(dt[31:1])),
    .den      (dt),
    .busy     (div_f_busy),
    .quotient (quo_f)
  );

  vae_div_ser #(.NW(NW), .DW(32)) u_div_ang (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .num      (NW'(prod_a) + NW'(dt[31:1])),
    .den      (dt),
    .busy     (div_a_busy),
    .quotient (quo_a)
  );

  // Stage three: one exponential filter lane per acceleration. The filter is
  // evaluated as prev*65536 + g*(raw - prev), so each lane needs a single product.
  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic signed [FNW-1:0] base;
    logic signed [FNW-1:0] pext;
    logic signed [FNW-1:0] rnd;
    logic signed [FNW-17:0] scaled;

    assign fmag[k] = (raw[k] < smoothed[k]) ? 32'(smoothed[k] - raw[k])
                                            : 32'(raw[k] - smoothed[k]);
    assign base = {{(FNW-48){smoothed[k][31]}}, smoothed[k], 16'd0};
    assign pext = $signed({{(FNW-FPW){1'b0}}, fprod[k]});

    // Dividing by 65536 with ties away from zero: an arithmetic shift after adding
    // one half for positive values and one half less one for negative values.
    assign rnd    = fnum[k] + (fnum[k][FNW-1] ? FNW'(32767) : FNW'(32768));
    assign scaled = rnd[FNW-1:16];

    vae_mul_ser #(.AW(32), .BW(GAIN_W)) u_mul_filt (
      .clk     (clk),
      .rst     (rst),
      .start   (filt_start),
      .a       (fmag[k]),
      .b       (gain_eff),
      .busy    (fbusy[k]),
      .product (fprod[k])
    );

    always_ff @(posedge clk) begin
      if (filt_start) begin
        fneg[k] <= raw[k] < smoothed[k];
      end
      if ((state == S_FMUL) && !(|fbusy)) begin
        fnum[k] <= fneg[k] ? (base - pext) : (base + pext);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        smoothed[k] <= '0;
      end else if (state == S_FNUM) begin
        if (scaled[FNW-17] && !(&scaled[FNW-18:31])) begin
          smoothed[k] <= 32'sh80000000;
        end else if (!scaled[FNW-17] && (|scaled[FNW-18:31])) begin
          smoothed[k] <= 32'sh7fffffff;
        end else begin
          smoothed[k] <= scaled[31:0];
        end
      end
    end
  end

  // Counter and stored sample; the stored sample is replaced by every request.
  always_ff @(posedge clk) begin
    if (rst) begin
      update_counter     <= '0;
      have_previous      <= 1'b0;
      previous_time      <= '0;
      previous_speed     <= '0;
      previous_turn_rate <= '0;
    end else begin
      if (state == S_FNUM) begin
        update_counter <= update_counter + 32'd1;
      end
      if (out_load) begin
        have_previous      <= 1'b1;
        previous_time      <= cur_time;
        previous_speed     <= cur_speed;
        previous_turn_rate <= cur_turn;
      end
    end
  end

  // Output register: holds the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      forward_accel <= smoothed[LANE_FWD];
      lateral_accel <= smoothed[LANE_LAT];
      angular_accel <= smoothed[LANE_ANG];
      status        <= item_status;
      updates_done  <= update_counter;
    end
  end

  // The update count moves only when a filter update is written back.
  a_counter_only_on_update: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (update_counter != $past(update_counter))) |-> $past(state == S_FNUM))
    else $error("update counter changed outside the filter write-back step");

  // A new result appears only out of the output step of the sequencer.
  a_result_from_out_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised without passing through the output step");

  // All serial units are quiet whenever the block waits for a request.
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(mul_busy || div_busy || (|fbusy)))
    else $error("serial unit still running while waiting for a request");

endmodule

`default_nettype wire
